>>> hdl/kths_pkg.sv
// shared types, constants and key helpers for the keyed table heap sort block
`timescale 1ns / 1ps
`default_nettype none
package kths_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int KEY_CHARS     = 27;
    localparam int TEXT_W        = 56;
    localparam int KEY_W         = 4 * TEXT_W + 32;
    localparam int REC_W         = KEY_W + 64;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_SORT   = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    // datapath operation codes
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_LOADA = 3'd1,
        OP_LOADB = 3'd2,
        OP_WRA   = 3'd3,
        OP_WRB   = 3'd4,
        OP_WRIN  = 3'd5,
        OP_PROBE = 3'd6
    } dp_op_t;

    // text truncated at first zero byte and after character 27
    function automatic logic [4*TEXT_W-1:0] canon_text(input logic [4*TEXT_W-1:0] raw);
        logic [4*TEXT_W-1:0] res;
        logic                ended;
        logic [7:0]          b;
        res   = '0;
        ended = 1'b0;
        for (int p = 0; p < 28; p++)
        begin
            b = raw[4*TEXT_W-1-8*p -: 8];
            if (p >= KEY_CHARS || b == 8'd0)
                ended = 1'b1;
            if (!ended)
                res[4*TEXT_W-1-8*p -: 8] = b;
        end
        return res;
    endfunction

    // maps key so that unsigned compare gives the key order
    function automatic logic [KEY_W-1:0] key_order(input logic [KEY_W-1:0] k);
        return {k[KEY_W-1:32], ~k[31], k[30:0]};
    endfunction

endpackage
`default_nettype wire

>>> hdl/kths_if.sv
// valid / ready channel interface
`timescale 1ns / 1ps
`default_nettype none
interface kths_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/kths_datapath.sv
// record memory, two record registers and key comparator
`timescale 1ns / 1ps
`default_nettype none
module kths_datapath
    import kths_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
)(
    input  wire logic             clk,
    input  wire dp_op_t           op,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [REC_W-1:0] in_rec,
    output logic [REC_W-1:0]      rec_a,
    output logic                  a_gt_b,
    output logic                  a_lt_b
);
    logic [REC_W-1:0] mem [DEPTH];
    logic [REC_W-1:0] rd_q;
    logic [REC_W-1:0] a_reg;
    logic [REC_W-1:0] b_reg;
    logic             load_a_reg;
    logic             load_b_reg;
    logic [KEY_W-1:0] ka;
    logic [KEY_W-1:0] kb;

    always_ff @(posedge clk)
    begin
        rd_q <= mem[addr];
        if (op == OP_WRA)
            mem[addr] <= a_reg;
        else if (op == OP_WRB)
            mem[addr] <= b_reg;
        else if (op == OP_WRIN)
            mem[addr] <= in_rec;
        load_a_reg <= (op == OP_LOADA);
        load_b_reg <= (op == OP_LOADB);
        if (load_a_reg)
            a_reg <= rd_q;
        // probe key enters b directly
        if (op == OP_PROBE)
            b_reg <= in_rec;
        else if (load_b_reg)
            b_reg <= rd_q;
    end

    assign ka     = key_order(a_reg[REC_W-1:64]);
    assign kb     = key_order(b_reg[REC_W-1:64]);
    assign a_gt_b = ka > kb;
    assign a_lt_b = ka < kb;
    assign rec_a  = a_reg;
endmodule
`default_nettype wire

>>> hdl/kths_ctrl.sv
// command sequencer for push, heap sort, search and read
`timescale 1ns / 1ps
`default_nettype none
module kths_ctrl
    import kths_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
)(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire cmd_t          cmd,
    input  wire logic [7:0]    read_index,
    input  wire logic          out_taken,
    input  wire logic          a_gt_b,
    input  wire logic          a_lt_b,
    output dp_op_t             op,
    output logic [AW-1:0]      addr,
    output logic               busy,
    output logic               done,
    output status_t            status,
    output logic [7:0]         found_index,
    output logic [CW-1:0]      count,
    output logic               sorted,
    output logic               show_rec
);
    typedef enum logic [4:0] {
        S_IDLE, S_PUSH, S_READ_WAIT, S_READ_DONE,
        S_BUILD_NEXT, S_SIFT_LOAD_I, S_SIFT_LOAD_L, S_SIFT_CMP_L,
        S_SIFT_LOAD_R, S_SIFT_CMP_R, S_SIFT_SWAP1, S_SIFT_SWAP2, S_SIFT_SWAP3,
        S_EXT_NEXT, S_EXT_LOAD0, S_EXT_LOADN, S_EXT_CMP, S_EXT_SWAP1,
        S_SRCH_STEP, S_SRCH_WAIT, S_SRCH_CMP, S_SRCH_END,
        S_WAIT_WAIT, S_RESULT
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           sorted_reg, sorted_next;
    status_t        status_reg, status_next;
    logic [7:0]     found_reg, found_next;
    logic           show_reg, show_next;
    logic [CW:0]    i_reg, i_next;      // sift position / loop counter
    logic [CW:0]    n_reg, n_next;      // heap size
    logic [CW:0]    top_reg, top_next;
    logic [CW:0]    j_reg, j_next;      // outer loop counter
    logic           build_reg, build_next;
    logic signed [CW+1:0] left_reg, left_next, right_reg, right_next;
    logic signed [CW+1:0] mid;
    logic [CW:0]    l_pos, r_pos;
    dp_op_t         op_reg, op_next;
    logic [AW-1:0]  addr_reg, addr_next;
    state_t         ret_reg, ret_next;
    logic [1:0]     wait_reg, wait_next;

    assign l_pos = {i_reg[CW-1:0], 1'b1};
    assign r_pos = l_pos + 1'b1;
    assign mid   = (left_reg + right_reg) >>> 1;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        sorted_next = sorted_reg;
        status_next = status_reg;
        found_next  = found_reg;
        show_next   = show_reg;
        i_next      = i_reg;
        n_next      = n_reg;
        top_next    = top_reg;
        j_next      = j_reg;
        build_next  = build_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        op_next     = OP_NONE;
        addr_next   = addr_reg;
        ret_next    = ret_reg;
        wait_next   = wait_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = ST_OK;
                    found_next  = '0;
                    show_next   = 1'b0;
                    case (cmd)
                        CMD_PUSH:
                        begin
                            sorted_next = 1'b0;
                            if (count_reg >= CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_RESULT;
                            end
                            else
                            begin
                                op_next    = OP_WRIN;
                                addr_next  = count_reg[AW-1:0];
                                count_next = count_reg + 1'b1;
                                state_next = S_RESULT;
                            end
                        end
                        CMD_SORT:
                        begin
                            sorted_next = 1'b1;
                            n_next      = {1'b0, count_reg};
                            j_next      = {1'b0, count_reg} >> 1;
                            build_next  = 1'b1;
                            state_next  = S_BUILD_NEXT;
                        end
                        CMD_SEARCH:
                        begin
                            // probe key goes into b without touching memory
                            op_next    = OP_PROBE;
                            left_next  = '1;
                            right_next = (CW+2)'(count_reg);
                            state_next = S_SRCH_STEP;
                        end
                        default:
                        begin
                            if ((CW+8)'(read_index) >= (CW+8)'(count_reg))
                            begin
                                status_next = ST_RANGE;
                                state_next  = S_RESULT;
                            end
                            else
                            begin
                                op_next    = OP_LOADA;
                                addr_next  = AW'(read_index);
                                wait_next  = 2'd2;
                                ret_next   = S_READ_DONE;
                                state_next = S_WAIT_WAIT;
                            end
                        end
                    endcase
                end
            end
            S_READ_DONE:
            begin
                show_next  = 1'b1;
                state_next = S_RESULT;
            end
            S_WAIT_WAIT:
            begin
                if (wait_reg == 2'd0)
                    state_next = ret_reg;
                else
                    wait_next = wait_reg - 1'b1;
            end
            S_BUILD_NEXT:
            begin
                if (j_reg == '0)
                begin
                    build_next = 1'b0;
                    j_next     = n_reg;
                    state_next = S_EXT_NEXT;
                end
                else
                begin
                    j_next     = j_reg - 1'b1;
                    i_next     = j_reg - 1'b1;
                    state_next = S_SIFT_LOAD_I;
                end
            end
            S_SIFT_LOAD_I:
            begin
                top_next   = i_reg;
                op_next    = OP_LOADB;
                addr_next  = i_reg[AW-1:0];
                wait_next  = 2'd2;
                ret_next   = S_SIFT_LOAD_L;
                state_next = S_WAIT_WAIT;
            end
            S_SIFT_LOAD_L:
            begin
                if (l_pos < n_reg)
                begin
                    op_next    = OP_LOADA;
                    addr_next  = l_pos[AW-1:0];
                    wait_next  = 2'd2;
                    ret_next   = S_SIFT_CMP_L;
                    state_next = S_WAIT_WAIT;
                end
                else
                    state_next = S_SIFT_LOAD_R;
            end
            S_SIFT_CMP_L:
            begin
                // b holds current top; a holds left child
                if (a_gt_b)
                begin
                    top_next  = l_pos;
                    op_next   = OP_LOADB;
                    addr_next = l_pos[AW-1:0];
                    wait_next = 2'd2;
                    ret_next  = S_SIFT_LOAD_R;
                    state_next = S_WAIT_WAIT;
                end
                else
                    state_next = S_SIFT_LOAD_R;
            end
            S_SIFT_LOAD_R:
            begin
                if (r_pos < n_reg)
                begin
                    op_next    = OP_LOADA;
                    addr_next  = r_pos[AW-1:0];
                    wait_next  = 2'd2;
                    ret_next   = S_SIFT_CMP_R;
                    state_next = S_WAIT_WAIT;
                end
                else
                    state_next = S_SIFT_SWAP1;
            end
            S_SIFT_CMP_R:
            begin
                if (a_gt_b)
                begin
                    top_next  = r_pos;
                    op_next   = OP_LOADB;
                    addr_next = r_pos[AW-1:0];
                    wait_next = 2'd2;
                    ret_next  = S_SIFT_SWAP1;
                    state_next = S_WAIT_WAIT;
                end
                else
                    state_next = S_SIFT_SWAP1;
            end
            S_SIFT_SWAP1:
            begin
                if (top_reg == i_reg)
                    state_next = build_reg ? S_BUILD_NEXT : S_EXT_NEXT;
                else
                begin
                    // b = record at top; load a = record at i
                    op_next    = OP_LOADA;
                    addr_next  = i_reg[AW-1:0];
                    wait_next  = 2'd2;
                    ret_next   = S_SIFT_SWAP2;
                    state_next = S_WAIT_WAIT;
                end
            end
            S_SIFT_SWAP2:
            begin
                op_next    = OP_WRB;
                addr_next  = i_reg[AW-1:0];
                state_next = S_SIFT_SWAP3;
            end
            S_SIFT_SWAP3:
            begin
                op_next    = OP_WRA;
                addr_next  = top_reg[AW-1:0];
                i_next     = top_reg;
                state_next = S_SIFT_LOAD_I;
            end
            S_EXT_NEXT:
            begin
                if (j_reg <= 1)
                    state_next = S_RESULT;
                else
                begin
                    op_next    = OP_LOADA;
                    addr_next  = '0;
                    wait_next  = 2'd2;
                    ret_next   = S_EXT_LOADN;
                    state_next = S_WAIT_WAIT;
                end
            end
            S_EXT_LOADN:
            begin
                op_next    = OP_LOADB;
                addr_next  = AW'(j_reg - 1'b1);
                wait_next  = 2'd2;
                ret_next   = S_EXT_CMP;
                state_next = S_WAIT_WAIT;
            end
            S_EXT_CMP:
            begin
                if (a_gt_b || a_lt_b)
                begin
                    op_next    = OP_WRB;
                    addr_next  = '0;
                    state_next = S_EXT_SWAP1;
                end
                else
                begin
                    j_next     = j_reg - 1'b1;
                    n_next     = j_reg - 1'b1;
                    i_next     = '0;
                    state_next = S_SIFT_LOAD_I;
                end
            end
            S_EXT_SWAP1:
            begin
                op_next    = OP_WRA;
                addr_next  = AW'(j_reg - 1'b1);
                j_next     = j_reg - 1'b1;
                n_next     = j_reg - 1'b1;
                i_next     = '0;
                state_next = S_SIFT_LOAD_I;
            end
            S_SRCH_STEP:
            begin
                if (right_reg - left_reg > 1)
                begin
                    op_next    = OP_LOADA;
                    addr_next  = mid[AW-1:0];
                    wait_next  = 2'd2;
                    ret_next   = S_SRCH_CMP;
                    state_next = S_WAIT_WAIT;
                end
                else
                    state_next = S_SRCH_END;
            end
            S_SRCH_CMP:
            begin
                if (a_lt_b)
                    left_next = mid;
                else
                    right_next = mid;
                state_next = S_SRCH_STEP;
            end
            S_SRCH_END:
            begin
                if (right_reg >= 0 && right_reg < (CW+2)'(count_reg))
                    found_next = 8'(right_reg);
                else
                    status_next = ST_NOT_FOUND;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_taken)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            sorted_reg <= 1'b0;
            status_reg <= ST_OK;
            found_reg  <= '0;
            show_reg   <= 1'b0;
            i_reg      <= '0;
            n_reg      <= '0;
            top_reg    <= '0;
            j_reg      <= '0;
            build_reg  <= 1'b0;
            left_reg   <= '0;
            right_reg  <= '0;
            op_reg     <= OP_NONE;
            addr_reg   <= '0;
            ret_reg    <= S_IDLE;
            wait_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sorted_reg <= sorted_next;
            status_reg <= status_next;
            found_reg  <= found_next;
            show_reg   <= show_next;
            i_reg      <= i_next;
            n_reg      <= n_next;
            top_reg    <= top_next;
            j_reg      <= j_next;
            build_reg  <= build_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            op_reg     <= op_next;
            addr_reg   <= addr_next;
            ret_reg    <= ret_next;
            wait_reg   <= wait_next;
        end
    end

    assign op          = op_reg;
    assign addr        = addr_reg;
    assign busy        = (state_reg != S_IDLE);
    assign done        = (state_reg == S_RESULT);
    assign status      = status_reg;
    assign found_index = found_reg;
    assign count       = count_reg;
    assign sorted      = sorted_reg;
    assign show_rec    = show_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH)) else $error("entry count above depth");
    a_push_unsorts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && start && cmd == CMD_PUSH) |=> !sorted_reg)
        else $error("push left table marked sorted");
    a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SRCH_STEP) |-> (right_reg > left_reg))
        else $error("search window inverted");
endmodule
`default_nettype wire

>>> hdl/keyed_table_heap_sort_search.sv
// top level: keyed record table with heap sort and lower-bound search
//
//  channel | dir | fields
//  in      | in  | cmd, key_text_0..3, key_number, payload, read_index
//  out     | out | status, found_index, entry_total, is_sorted, out_text_0..3,
//          |     | out_number, out_payload
//
// one command at a time; every memory read costs a read plus two register stages
// a search makes ceil(log2(count+1)) probes; a sort runs O(n log n) sift levels
// all memory traffic goes through the single port of the record memory
// reset clears count and sorted flag; record memory is not cleared
// the result word holds until taken; input stalls while a command is busy
`timescale 1ns / 1ps
`default_nettype none
module keyed_table_heap_sort_search
    import kths_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)(
    input wire logic clk,
    input wire logic rst_n,
    kths_if.sink     in_ch,
    kths_if.source   out_ch
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic             start;
    dp_op_t           op;
    logic [AW-1:0]    addr;
    logic [REC_W-1:0] in_rec;
    logic [REC_W-1:0] rec_a;
    logic             a_gt_b, a_lt_b, busy, done, sorted, show_rec;
    status_t          status;
    logic [7:0]       found_index;
    logic [CW-1:0]    count;
    logic [REC_W-1:0] probe_reg;

    assign in_ch.ready = !busy;
    assign start       = in_ch.valid && in_ch.ready;
    assign in_rec = {canon_text({in_ch.data.key_text_0, in_ch.data.key_text_1,
                                 in_ch.data.key_text_2, in_ch.data.key_text_3}),
                     in_ch.data.key_number, in_ch.data.payload};

    always_ff @(posedge clk)
    begin
        if (start)
            probe_reg <= in_rec;
    end

    kths_datapath #(.DEPTH(DEPTH), .AW(AW)) u_dp (
        .clk    (clk),
        .op     (op),
        .addr   (addr),
        .in_rec (probe_reg),
        .rec_a  (rec_a),
        .a_gt_b (a_gt_b),
        .a_lt_b (a_lt_b)
    );

    kths_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd_t'(in_ch.data.cmd)),
        .read_index  (in_ch.data.read_index),
        .out_taken   (out_ch.ready),
        .a_gt_b      (a_gt_b),
        .a_lt_b      (a_lt_b),
        .op          (op),
        .addr        (addr),
        .busy        (busy),
        .done        (done),
        .status      (status),
        .found_index (found_index),
        .count       (count),
        .sorted      (sorted),
        .show_rec    (show_rec)
    );

    assign out_ch.valid            = done;
    assign out_ch.data.status      = status;
    assign out_ch.data.found_index = found_index;
    assign out_ch.data.entry_total = 9'(count);
    assign out_ch.data.is_sorted   = sorted;
    assign out_ch.data.out_text_0  = show_rec ? rec_a[REC_W-1 -: 56] : '0;
    assign out_ch.data.out_text_1  = show_rec ? rec_a[REC_W-57 -: 56] : '0;
    assign out_ch.data.out_text_2  = show_rec ? rec_a[REC_W-113 -: 56] : '0;
    assign out_ch.data.out_text_3  = show_rec ? rec_a[REC_W-169 -: 56] : '0;
    assign out_ch.data.out_number  = show_rec ? rec_a[95:64] : '0;
    assign out_ch.data.out_payload = show_rec ? rec_a[63:0] : '0;
endmodule
`default_nettype wire
